// ===== rtl/fcsa_pkg.sv =====
// ----------------------------------------------------------------------------
// fcsa_pkg - shared definitions for the fixed chunk stack allocator
// Field widths, command, status and register codes, and default sizes.
// ----------------------------------------------------------------------------
package fcsa_pkg;

  // Field widths
  localparam int ADDR_W     = 48;
  localparam int SIZE_W     = 17;
  localparam int CNT_W      = 11;
  localparam int REQ_W      = 32;
  localparam int BYTES_W    = 27;
  localparam int CTR_W      = 32;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // Default sizing and register reset values
  localparam int DEF_MAX_CHUNKS  = 1024;
  localparam int DEF_ADDR_BITS   = 48;
  localparam int RST_BLOCK_BYTES = 4096;
  localparam int RST_CHUNK_COUNT = 1024;

  // Commands
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC      = 2'd0,
    CMD_FREE       = 2'd1,
    CMD_RESET_POOL = 2'd2
  } cmd_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE        = 3'd0,
    ST_ZERO_SIZE   = 3'd1,
    ST_TOO_LARGE   = 3'd2,
    ST_POOL_EMPTY  = 3'd3,
    ST_BAD_ADDRESS = 3'd4,
    ST_STACK_FULL  = 3'd5
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAP_BASE   = 2'd0,
    CFG_BLOCK_BYTES = 2'd1,
    CFG_CHUNK_COUNT = 2'd2
  } cfg_index_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/fcsa_if.sv =====
// ----------------------------------------------------------------------------
// fcsa_if - request and response channels of the chunk allocator
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface fcsa_req_if;
  logic                           valid;
  logic                           ready;
  logic [fcsa_pkg::CMD_W-1:0]     command;
  logic [fcsa_pkg::REQ_W-1:0]     request_size;
  logic [fcsa_pkg::ADDR_W-1:0]    release_address;

  modport source (output valid, command, request_size, release_address, input ready);
  modport sink   (input valid, command, request_size, release_address, output ready);
endinterface

interface fcsa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [fcsa_pkg::STATUS_W-1:0]  status;
  logic [fcsa_pkg::ADDR_W-1:0]    chunk_address;
  logic [fcsa_pkg::CNT_W-1:0]     free_chunks;
  logic [fcsa_pkg::BYTES_W-1:0]   used_bytes;
  logic [fcsa_pkg::BYTES_W-1:0]   free_bytes;
  logic [fcsa_pkg::CTR_W-1:0]     allocations_total;
  logic [fcsa_pkg::CTR_W-1:0]     frees_total;
  logic [fcsa_pkg::CTR_W-1:0]     failures_total;

  modport source (output valid, status, chunk_address, free_chunks, used_bytes, free_bytes,
                  allocations_total, frees_total, failures_total, input ready);
  modport sink   (input valid, status, chunk_address, free_chunks, used_bytes, free_bytes,
                  allocations_total, frees_total, failures_total, output ready);
endinterface

// ===== rtl/fcsa_ram.sv =====
// ----------------------------------------------------------------------------
// fcsa_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module fcsa_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fcsa_div.sv =====
// ----------------------------------------------------------------------------
// fcsa_div - iterative restoring divider
// Produces a QW-bit quotient, one bit per cycle. The caller guarantees the
// quotient fits, so the upper dividend bits are already below the divisor.
// ----------------------------------------------------------------------------
module fcsa_div #(
  parameter int QW = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fcsa_pkg::ADDR_W-1:0]   dividend,
  input  logic [fcsa_pkg::SIZE_W-1:0]   divisor,
  output logic [QW-1:0]                 quotient,
  output fcsa_pkg::div_stat_t           stat
);

  localparam int SW = fcsa_pkg::SIZE_W;
  localparam int CW = $clog2(QW + 1);

  logic [SW-1:0] rem;
  logic [QW-1:0] quo;
  logic [CW-1:0] steps;
  logic          busy;
  logic          done;
  logic [SW:0]   trial;
  logic [SW:0]   shifted;
  logic          qbit;

  // Shift the next dividend bit in and try the subtraction
  assign shifted = {rem, quo[QW-1]};
  assign trial   = shifted - {1'b0, divisor};
  assign qbit    = (shifted >= {1'b0, divisor});

  // Run one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= SW'(dividend >> QW);
        quo   <= dividend[QW-1:0];
        steps <= CW'(QW);
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= qbit ? trial[SW-1:0] : shifted[SW-1:0];
        quo   <= QW'({quo, qbit});
        steps <= steps - CW'(1);
        if (steps == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

  // Start only when idle
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  // Done follows the final step
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a run");
  // Step count stays within the quotient width
  a_steps_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (steps != '0) && (32'(steps) <= 32'(QW)))
    else $error("divider step count out of range");

endmodule

// ===== rtl/fixed_chunk_stack_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_chunk_stack_allocator - fixed-size chunk allocator on a free stack
// Allocate pops a free chunk index, free pushes the index of the chunk that
// holds an address, reset pool marks every chunk free again.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command (allocate, free, reset pool) with its size or
//   address; rsp returns one result per request: status, chunk address,
//   usage figures and the three wrapping event counters.
//   cfg_we/cfg_index/cfg_data write heap_base (0), block_bytes (1) and
//   chunk_count (2); write them only while no request is in flight.
//   An accepted free runs the bit-serial divider that turns an address into
//   a chunk index; the multiplier is shared by the chunk address, bounds
//   and usage figures. One request is worked at a time; the next one is
//   taken the cycle after the previous result is registered.
//   After reset the free stack is filled with entry i = i, during which
//   req.ready stays low.
//   A finished result waits in the output register while rsp.ready is low;
//   the next request may be taken meanwhile and its result is held until
//   the output register drains.
// ----------------------------------------------------------------------------
module fixed_chunk_stack_allocator #(
  parameter int MAX_CHUNKS = fcsa_pkg::DEF_MAX_CHUNKS,
  parameter int ADDR_BITS  = fcsa_pkg::DEF_ADDR_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  fcsa_req_if.sink                          req,
  fcsa_rsp_if.source                        rsp,
  input  logic                              cfg_we,
  input  logic [fcsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fcsa_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W   = $clog2(MAX_CHUNKS);
  localparam int AW_     = fcsa_pkg::ADDR_W;
  localparam int SW      = fcsa_pkg::SIZE_W;
  localparam int CW      = fcsa_pkg::CNT_W;
  localparam int MA_W    = (IDX_W > CW) ? IDX_W : CW;
  localparam int PW      = MA_W + SW;
  localparam int BW      = fcsa_pkg::BYTES_W;
  localparam int TOP_RST_I = (fcsa_pkg::RST_CHUNK_COUNT > MAX_CHUNKS) ?
                             MAX_CHUNKS : fcsa_pkg::RST_CHUNK_COUNT;
  localparam logic [CW-1:0]  TOP_RST  = CW'(TOP_RST_I);
  localparam logic [AW_-1:0] ADDR_MASK = (ADDR_BITS >= AW_) ? {AW_{1'b1}} :
                                         AW_'((64'd1 << ADDR_BITS) - 64'd1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_ALLOC_RD,
    S_ALLOC_MUL,
    S_ALLOC_ADD,
    S_FREE_MUL,
    S_FREE_CHK,
    S_FREE_DIV,
    S_FREE_PUSH,
    S_MUL_USED,
    S_MUL_FREE,
    S_OUT
  } state_t;

  // Configuration registers
  logic [AW_-1:0] heap_base;
  logic [SW-1:0]  block_bytes;
  logic [CW-1:0]  chunk_count;

  // Sequencer state
  state_t               state;
  logic [IDX_W-1:0]     clr_idx;
  logic [CW-1:0]        stack_top;
  logic [fcsa_pkg::CTR_W-1:0] alloc_counter;
  logic [fcsa_pkg::CTR_W-1:0] free_counter;
  logic [fcsa_pkg::CTR_W-1:0] fail_counter;
  logic [fcsa_pkg::REQ_W-1:0] size_q;
  logic [AW_-1:0]             addr_q;
  logic [fcsa_pkg::STATUS_W-1:0] status_q;
  logic [AW_-1:0]             chunk_addr_q;
  logic [BW-1:0]              used_bytes_q;
  logic [PW-1:0]              prod;

  // Output register
  logic                          out_valid;
  logic [fcsa_pkg::STATUS_W-1:0] out_status;
  logic [AW_-1:0]                out_chunk_address;
  logic [CW-1:0]                 out_free_chunks;
  logic [BW-1:0]                 out_used_bytes;
  logic [BW-1:0]                 out_free_bytes;
  logic [fcsa_pkg::CTR_W-1:0]    out_allocations;
  logic [fcsa_pkg::CTR_W-1:0]    out_frees;
  logic [fcsa_pkg::CTR_W-1:0]    out_failures;

  // Datapath signals
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      used;
  logic [MA_W-1:0]    mul_a;
  logic [PW-1:0]      mul_p;
  logic [AW_:0]       heap_end;
  logic               addr_bad;
  logic               div_start;
  logic [IDX_W-1:0]   quotient;
  fcsa_pkg::div_stat_t div_stat;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [IDX_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]   ram_rdata;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base   <= '0;
      block_bytes <= SW'(fcsa_pkg::RST_BLOCK_BYTES);
      chunk_count <= CW'(fcsa_pkg::RST_CHUNK_COUNT);
    end else if (cfg_we) begin
      case (cfg_index)
        fcsa_pkg::CFG_HEAP_BASE:   heap_base   <= cfg_data[AW_-1:0];
        fcsa_pkg::CFG_BLOCK_BYTES: block_bytes <= cfg_data[SW-1:0];
        fcsa_pkg::CFG_CHUNK_COUNT: chunk_count <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the chunk count to the stack depth
  assign cnt  = (32'(chunk_count) > 32'(MAX_CHUNKS)) ? CW'(MAX_CHUNKS) : chunk_count;
  assign used = (cnt > stack_top) ? (cnt - stack_top) : '0;

  // Select the shared multiplier operand by step; hold the free figure while the
  // result waits
  always_comb begin
    case (state)
      S_ALLOC_MUL: mul_a = MA_W'(ram_rdata);
      S_FREE_MUL:  mul_a = MA_W'(cnt);
      S_MUL_USED:  mul_a = MA_W'(used);
      S_MUL_FREE:  mul_a = MA_W'(stack_top);
      S_OUT:       mul_a = MA_W'(stack_top);
      default:     mul_a = '0;
    endcase
  end
  assign mul_p = PW'(mul_a) * PW'(block_bytes);

  // Heap bounds check on the registered product
  assign heap_end  = {1'b0, heap_base} + (AW_ + 1)'(prod);
  assign addr_bad  = (addr_q == '0) || (addr_q < heap_base) ||
                     ({1'b0, addr_q} >= heap_end);
  assign div_start = (state == S_FREE_CHK) && !addr_bad && (stack_top < cnt);

  // Free stack storage: clearing sweep and pushes write, pops read
  assign ram_we    = (state == S_CLEAR) || (state == S_FREE_PUSH);
  assign ram_waddr = (state == S_CLEAR) ? clr_idx : IDX_W'(stack_top);
  assign ram_wdata = (state == S_CLEAR) ? clr_idx : quotient;

  fcsa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_CHUNKS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (IDX_W'(stack_top)),
    .rdata (ram_rdata)
  );

  fcsa_div #(
    .QW (IDX_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (addr_q - heap_base),
    .divisor  (block_bytes),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      stack_top     <= TOP_RST;
      alloc_counter <= '0;
      free_counter  <= '0;
      fail_counter  <= '0;
      out_valid     <= 1'b0;
    end else begin
      prod <= mul_p;
      // Drop a taken result; the output step reloads the register itself
      if (rsp.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (clr_idx == IDX_W'(MAX_CHUNKS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            size_q       <= req.request_size;
            addr_q       <= req.release_address;
            status_q     <= fcsa_pkg::ST_DONE;
            chunk_addr_q <= '0;
            case (req.command)
              fcsa_pkg::CMD_ALLOC: state <= S_ALLOC;
              fcsa_pkg::CMD_FREE:  state <= S_FREE_MUL;
              default:             state <= S_MUL_USED;
            endcase
            if (req.command == fcsa_pkg::CMD_RESET_POOL) begin
              stack_top <= cnt;
            end
          end
        end
        S_ALLOC: begin
          if (size_q == '0) begin
            status_q     <= fcsa_pkg::ST_ZERO_SIZE;
            fail_counter <= fail_counter + 1'b1;
            state        <= S_MUL_USED;
          end else if (size_q > 32'(block_bytes)) begin
            status_q     <= fcsa_pkg::ST_TOO_LARGE;
            fail_counter <= fail_counter + 1'b1;
            state        <= S_MUL_USED;
          end else if (stack_top == '0) begin
            status_q     <= fcsa_pkg::ST_POOL_EMPTY;
            fail_counter <= fail_counter + 1'b1;
            state        <= S_MUL_USED;
          end else begin
            stack_top <= stack_top - CW'(1);
            state     <= S_ALLOC_RD;
          end
        end
        S_ALLOC_RD: begin
          state <= S_ALLOC_MUL;
        end
        S_ALLOC_MUL: begin
          state <= S_ALLOC_ADD;
        end
        S_ALLOC_ADD: begin
          chunk_addr_q  <= (heap_base + AW_'(prod)) & ADDR_MASK;
          alloc_counter <= alloc_counter + 1'b1;
          state         <= S_MUL_USED;
        end
        S_FREE_MUL: begin
          state <= S_FREE_CHK;
        end
        S_FREE_CHK: begin
          if (addr_bad) begin
            status_q <= fcsa_pkg::ST_BAD_ADDRESS;
            state    <= S_MUL_USED;
          end else if (stack_top >= cnt) begin
            status_q <= fcsa_pkg::ST_STACK_FULL;
            state    <= S_MUL_USED;
          end else begin
            state <= S_FREE_DIV;
          end
        end
        S_FREE_DIV: begin
          if (div_stat.done) begin
            state <= S_FREE_PUSH;
          end
        end
        S_FREE_PUSH: begin
          stack_top    <= stack_top + CW'(1);
          free_counter <= free_counter + 1'b1;
          state        <= S_MUL_USED;
        end
        S_MUL_USED: begin
          state <= S_MUL_FREE;
        end
        S_MUL_FREE: begin
          used_bytes_q <= prod[BW-1:0];
          state        <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || rsp.ready) begin
            out_valid         <= 1'b1;
            out_status        <= status_q;
            out_chunk_address <= chunk_addr_q;
            out_free_chunks   <= stack_top;
            out_used_bytes    <= used_bytes_q;
            out_free_bytes    <= prod[BW-1:0];
            out_allocations   <= alloc_counter;
            out_frees         <= free_counter;
            out_failures      <= fail_counter;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready             = (state == S_IDLE);
  assign rsp.valid             = out_valid;
  assign rsp.status            = out_status;
  assign rsp.chunk_address     = out_chunk_address;
  assign rsp.free_chunks       = out_free_chunks;
  assign rsp.used_bytes        = out_used_bytes;
  assign rsp.free_bytes        = out_free_bytes;
  assign rsp.allocations_total = out_allocations;
  assign rsp.frees_total       = out_frees;
  assign rsp.failures_total    = out_failures;

  // Stack top never passes the stack depth
  a_top_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(stack_top) <= 32'(MAX_CHUNKS))
    else $error("stack top beyond stack depth");
  // A push only lands below the chunk count
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_FREE_PUSH) |-> (stack_top < cnt))
    else $error("push onto a full stack");
  // The allocation counter advances by at most one per cycle
  a_alloc_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (alloc_counter == $past(alloc_counter)) ||
                    (alloc_counter == $past(alloc_counter) + 1'b1))
    else $error("allocation counter jumped");
  // The divider only runs during a free
  a_div_in_free: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == S_FREE_DIV))
    else $error("divider busy outside a free");

endmodule

// ===== verif/chunk_pool_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_pool_checker - result checker for the fixed chunk stack allocator
// Watches the request, result and register channels, keeps its own copy of
// the free stack, the counters and the heap layout, works out the result of
// every accepted request and compares each returned result, field by field,
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module chunk_pool_checker (
  input  logic                            clk,
  input  logic                            rst,
  fcsa_req_if                             req,
  fcsa_rsp_if                             rsp,
  input  logic                            cfg_we,
  input  logic [fcsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fcsa_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                     mismatches,
  output int unsigned                     outstanding
);

  localparam int DEPTH   = fcsa_pkg::DEF_MAX_CHUNKS;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int ADDR_W  = fcsa_pkg::ADDR_W;
  localparam int SIZE_W  = fcsa_pkg::SIZE_W;
  localparam int CNT_W   = fcsa_pkg::CNT_W;
  localparam int BYTES_W = fcsa_pkg::BYTES_W;
  localparam int CTR_W   = fcsa_pkg::CTR_W;
  localparam int CMD_W   = fcsa_pkg::CMD_W;
  localparam int REQ_W   = fcsa_pkg::REQ_W;

  typedef struct packed {
    fcsa_pkg::status_t  status;
    logic [ADDR_W-1:0]  chunk_address;
    logic [CNT_W-1:0]   free_chunks;
    logic [BYTES_W-1:0] used_bytes;
    logic [BYTES_W-1:0] free_bytes;
    logic [CTR_W-1:0]   allocations_total;
    logic [CTR_W-1:0]   frees_total;
    logic [CTR_W-1:0]   failures_total;
  } pool_result_t;

  // Shadow of the allocator state and heap layout
  logic [IDX_W-1:0]  free_list [DEPTH];
  logic [CNT_W-1:0]  free_top;
  logic [CTR_W-1:0]  n_allocs;
  logic [CTR_W-1:0]  n_frees;
  logic [CTR_W-1:0]  n_fails;
  logic [ADDR_W-1:0] heap_base;
  logic [SIZE_W-1:0] block_bytes;
  logic [CNT_W-1:0]  chunk_count;

  pool_result_t pending_results [$];

  // Apply one request to the shadow state and return the result it causes
  function automatic pool_result_t apply_request(input logic [CMD_W-1:0] cmd,
                                                 input logic [REQ_W-1:0] size,
                                                 input logic [ADDR_W-1:0] addr);
    pool_result_t r;
    logic [CNT_W-1:0] usable;
    logic [CNT_W-1:0] in_use;
    logic [63:0] heap_end;
    logic [63:0] wide;

    r = '0;
    r.status = fcsa_pkg::ST_DONE;
    usable = (chunk_count > DEPTH) ? CNT_W'(DEPTH) : chunk_count;

    case (cmd)
      fcsa_pkg::CMD_ALLOC: begin
        if (size == '0) begin
          r.status = fcsa_pkg::ST_ZERO_SIZE;
        end else if (size > block_bytes) begin
          r.status = fcsa_pkg::ST_TOO_LARGE;
        end else if (free_top == '0) begin
          r.status = fcsa_pkg::ST_POOL_EMPTY;
        end else begin
          free_top = free_top - 1'b1;
          wide = 64'(heap_base) + 64'(free_list[free_top % DEPTH]) * 64'(block_bytes);
          r.chunk_address = wide[ADDR_W-1:0];
          n_allocs = n_allocs + 1'b1;
        end
        if (r.status != fcsa_pkg::ST_DONE) n_fails = n_fails + 1'b1;
      end
      fcsa_pkg::CMD_FREE: begin
        heap_end = 64'(heap_base) + 64'(usable) * 64'(block_bytes);
        if (addr == '0 || addr < heap_base || 64'(addr) >= heap_end) begin
          r.status = fcsa_pkg::ST_BAD_ADDRESS;
        end else if (free_top >= usable) begin
          r.status = fcsa_pkg::ST_STACK_FULL;
        end else begin
          // a nonempty heap implies a nonzero chunk size
          wide = (64'(addr) - 64'(heap_base)) / 64'(block_bytes);
          free_list[free_top % DEPTH] = wide[IDX_W-1:0];
          free_top = free_top + 1'b1;
          n_frees = n_frees + 1'b1;
        end
      end
      fcsa_pkg::CMD_RESET_POOL: begin
        free_top = usable;
      end
      default: begin
      end
    endcase

    in_use = (usable > free_top) ? usable - free_top : '0;
    r.free_chunks = free_top;
    wide = 64'(in_use) * 64'(block_bytes);
    r.used_bytes = wide[BYTES_W-1:0];
    wide = 64'(free_top) * 64'(block_bytes);
    r.free_bytes = wide[BYTES_W-1:0];
    r.allocations_total = n_allocs;
    r.frees_total = n_frees;
    r.failures_total = n_fails;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, field, want_v, got_v);
      mismatches++;
    end
  endtask

  // Track register writes, predict on each request, compare each result
  always @(posedge clk) begin : track
    pool_result_t want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) free_list[i] = IDX_W'(i);
      free_top    = (fcsa_pkg::RST_CHUNK_COUNT > DEPTH) ? CNT_W'(DEPTH) :
                    CNT_W'(fcsa_pkg::RST_CHUNK_COUNT);
      n_allocs    = '0;
      n_frees     = '0;
      n_fails     = '0;
      heap_base   = '0;
      block_bytes = SIZE_W'(fcsa_pkg::RST_BLOCK_BYTES);
      chunk_count = CNT_W'(fcsa_pkg::RST_CHUNK_COUNT);
      mismatches  = 0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fcsa_pkg::CFG_HEAP_BASE:   heap_base   = cfg_data[ADDR_W-1:0];
          fcsa_pkg::CFG_BLOCK_BYTES: block_bytes = cfg_data[SIZE_W-1:0];
          fcsa_pkg::CFG_CHUNK_COUNT: chunk_count = cfg_data[CNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no request outstanding, status %0d",
                   $time, rsp.status);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 64'(want.status), 64'(rsp.status));
          check_field("chunk_address", 64'(want.chunk_address), 64'(rsp.chunk_address));
          check_field("free_chunks", 64'(want.free_chunks), 64'(rsp.free_chunks));
          check_field("used_bytes", 64'(want.used_bytes), 64'(rsp.used_bytes));
          check_field("free_bytes", 64'(want.free_bytes), 64'(rsp.free_bytes));
          check_field("allocations_total", 64'(want.allocations_total),
                      64'(rsp.allocations_total));
          check_field("frees_total", 64'(want.frees_total), 64'(rsp.frees_total));
          check_field("failures_total", 64'(want.failures_total),
                      64'(rsp.failures_total));
        end
      end
      if (req.valid && req.ready)
        pending_results.push_back(apply_request(req.command, req.request_size,
                                                req.release_address));
    end
    outstanding <= pending_results.size();
  end

endmodule

// ===== verif/tb_fixed_chunk_stack_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_chunk_stack_allocator - testbench for the chunk allocator
// Sends a short directed list of requests, then long runs of mostly
// well-formed allocate and free traffic under a series of heap layouts,
// with random gaps on both channels and one long result back-pressure.
// Checking is done by chunk_pool_checker beside the block.
// ----------------------------------------------------------------------------
module tb_fixed_chunk_stack_allocator;

  localparam int ADDR_W     = fcsa_pkg::ADDR_W;
  localparam int SIZE_W     = fcsa_pkg::SIZE_W;
  localparam int CNT_W      = fcsa_pkg::CNT_W;
  localparam int REQ_W      = fcsa_pkg::REQ_W;
  localparam int CMD_W      = fcsa_pkg::CMD_W;
  localparam int CFG_IDX_W  = fcsa_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = fcsa_pkg::CFG_DATA_W;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int TARGET_REQUESTS = 1700;
  localparam int SETTLE_CYCLES   = 30;
  localparam int LONG_HOLD       = 400;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           mismatches;
  int unsigned           outstanding;

  // Stimulus copy of the heap layout
  logic [ADDR_W-1:0] lay_base;
  logic [SIZE_W-1:0] lay_size;
  logic [CNT_W-1:0]  lay_count;
  logic              back_to_back;
  logic              long_hold_due;
  int unsigned       requests_sent;

  fcsa_req_if req ();
  fcsa_rsp_if rsp ();

  fixed_chunk_stack_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  chunk_pool_checker pool_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] any_address();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Offer one request after a random gap and hold it until taken
  task automatic offer_request(input logic [CMD_W-1:0] cmd, input logic [REQ_W-1:0] size,
                               input logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = back_to_back ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid           <= 1'b1;
    req.command         <= cmd;
    req.request_size    <= size;
    req.release_address <= addr;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    requests_sent++;
  endtask

  // Mostly well-formed traffic, with boundary addresses and noise mixed in
  task automatic offer_mixed_request(input int unsigned alloc_pct);
    int unsigned       pick;
    int unsigned       usable;
    logic [63:0]       span;
    logic [CMD_W-1:0]  cmd;
    logic [REQ_W-1:0]  size;
    logic [ADDR_W-1:0] addr;
    pick   = $urandom_range(0, 99);
    usable = (lay_count > fcsa_pkg::DEF_MAX_CHUNKS) ? fcsa_pkg::DEF_MAX_CHUNKS : lay_count;
    span   = 64'(usable) * 64'(lay_size);
    size   = $urandom;
    addr   = any_address();
    if (pick < 4) begin
      cmd = fcsa_pkg::CMD_RESET_POOL;
    end else if (pick < 6) begin
      cmd = CMD_UNUSED;
    end else if (pick < 10) begin
      cmd = fcsa_pkg::CMD_ALLOC;
      if ($urandom_range(0, 1) == 0) size = '0;
    end else if (pick < 16) begin
      cmd = fcsa_pkg::CMD_FREE;
      case ($urandom_range(0, 4))
        0: addr = '0;
        1: addr = lay_base - 1'b1;
        2: addr = ADDR_W'(64'(lay_base) + span);
        3: addr = ADDR_W'(64'(lay_base) + span - 1);
        default: begin
        end
      endcase
    end else if ($urandom_range(0, 99) < alloc_pct) begin
      cmd = fcsa_pkg::CMD_ALLOC;
      case ($urandom_range(0, 7))
        0: size = REQ_W'(lay_size);
        1: size = REQ_W'(lay_size) + 1'b1;
        default: size = $urandom_range(1, (lay_size == '0) ? 1 : lay_size);
      endcase
    end else begin
      cmd = fcsa_pkg::CMD_FREE;
      if (span != 0)
        addr = ADDR_W'(64'(lay_base) + 64'($urandom_range(0, usable - 1)) * 64'(lay_size)
                       + 64'($urandom_range(0, lay_size - 1)));
    end
    offer_request(cmd, size, addr);
  endtask

  // Drop valid and hold until every result is back and the block has settled
  task automatic wait_until_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_layout(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                             input logic [CNT_W-1:0] count);
    lay_base  = base;
    lay_size  = size;
    lay_count = count;
    cfg_we    <= 1'b1;
    cfg_index <= fcsa_pkg::CFG_HEAP_BASE;
    cfg_data  <= CFG_DATA_W'(base);
    @(posedge clk);
    cfg_index <= fcsa_pkg::CFG_BLOCK_BYTES;
    cfg_data  <= CFG_DATA_W'(size);
    @(posedge clk);
    cfg_index <= fcsa_pkg::CFG_CHUNK_COUNT;
    cfg_data  <= CFG_DATA_W'(count);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_layout(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                            input logic [CNT_W-1:0] count, input int unsigned n,
                            input int unsigned alloc_pct);
    wait_until_drained();
    load_layout(base, size, count);
    back_to_back = ($urandom_range(0, 3) == 0);
    repeat (n) offer_mixed_request(alloc_pct);
  endtask

  // Result side: random stalls, stretches with none, one long hold-off
  initial begin : take_results
    int unsigned stall;
    int unsigned taken;
    logic        held;
    taken = 0;
    held  = 1'b0;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    rsp.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        taken++;
        if (long_hold_due && !held) begin
          stall = LONG_HOLD;
          held  = 1'b1;
        end else if ((taken / 96) % 3 == 0) begin
          stall = 0;
        end else begin
          stall = $urandom_range(0, 14);
        end
        if (stall != 0) begin
          rsp.ready <= 1'b0;
          repeat (stall) @(posedge clk);
          rsp.ready <= 1'b1;
        end
      end
    end
  end

  // Request side and verdict
  initial begin
    req.valid           <= 1'b0;
    req.command         <= fcsa_pkg::CMD_ALLOC;
    req.request_size    <= '0;
    req.release_address <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= fcsa_pkg::CFG_HEAP_BASE;
    cfg_data            <= '0;
    rst                 <= 1'b1;
    lay_base      = '0;
    lay_size      = SIZE_W'(fcsa_pkg::RST_BLOCK_BYTES);
    lay_count     = CNT_W'(fcsa_pkg::RST_CHUNK_COUNT);
    back_to_back  = 1'b0;
    long_hold_due = 1'b0;
    requests_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset layout: full pool, boundary sizes and addresses, odd commands
    offer_request(fcsa_pkg::CMD_FREE, $urandom, 48'd4096);
    offer_request(fcsa_pkg::CMD_FREE, $urandom, '0);
    offer_request(fcsa_pkg::CMD_FREE, $urandom, 48'd4194304);
    offer_request(fcsa_pkg::CMD_FREE, $urandom, 48'hFFFF_FFFF_FFFF);
    offer_request(fcsa_pkg::CMD_ALLOC, '0, any_address());
    offer_request(fcsa_pkg::CMD_ALLOC, 32'd4097, any_address());
    offer_request(fcsa_pkg::CMD_ALLOC, 32'hFFFF_FFFF, any_address());
    offer_request(fcsa_pkg::CMD_ALLOC, 32'd4096, any_address());
    offer_request(fcsa_pkg::CMD_ALLOC, 32'd1, any_address());
    offer_request(fcsa_pkg::CMD_FREE, $urandom, 48'd4194303);
    offer_request(fcsa_pkg::CMD_FREE, $urandom, 48'd1);
    offer_request(CMD_UNUSED, $urandom, any_address());
    offer_request(fcsa_pkg::CMD_RESET_POOL, $urandom, any_address());
    offer_request(fcsa_pkg::CMD_ALLOC, 32'd2048, any_address());

    // Tiny pools, wrapping addresses, widest figures, zero chunk size
    run_layout('0, 17'd64, 11'd4, 60, 55);
    run_layout(48'hFFFF_FFFF_F000, 17'd65536, 11'd8, 60, 50);
    run_layout(any_address(), 17'd1, 11'd1, 40, 50);
    run_layout(any_address(), 17'h1FFFF, 11'h7FF, 80, 60);
    run_layout(any_address(), '0, 11'd16, 40, 50);

    // Full-size pool under a long result hold-off, so the input stalls
    wait_until_drained();
    load_layout({16'd0, 32'($urandom)}, 17'd4096, 11'd1024);
    back_to_back  = 1'b0;
    long_hold_due = 1'b1;
    repeat (150) offer_mixed_request(35);

    // Count lowered below the stack top, then an empty heap at the top end
    run_layout(any_address(), 17'd512, 11'd3, 60, 50);
    run_layout(48'hFFFF_FFFF_FFFF, 17'd1, '0, 40, 50);

    while (requests_sent < TARGET_REQUESTS) begin : random_layouts
      logic [SIZE_W-1:0] size;
      logic [CNT_W-1:0]  count;
      case ($urandom_range(0, 3))
        0: size = SIZE_W'($urandom_range(1, 16));
        1: size = SIZE_W'($urandom_range(1, 65536));
        2: size = 17'd65536;
        default: size = SIZE_W'($urandom_range(17, 4096));
      endcase
      count = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(0, 2047)) :
                                            CNT_W'($urandom_range(1, 24));
      run_layout(($urandom_range(0, 1) == 0) ? any_address() : ADDR_W'($urandom_range(0, 1 << 20)),
                 size, count, $urandom_range(30, 80), $urandom_range(25, 75));
    end

    wait_until_drained();
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
